// File: sv/deadline_timer_queue_macros.svh
// Assertion macros used by the deadline timer queue sequencer (dtq_ctrl).
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// Check an invariant at every clock edge outside reset.
`define DTQ_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define DTQ_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define DTQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dtq_pkg.sv
// Types and constants shared by the deadline timer queue modules.
package dtq_pkg;

  // Most expiry notices emitted for one tick
  localparam int MAX_RESULTS = 16;

  // Highest accepted interface revision
  localparam logic [7:0] REV_MAX = 8'd1;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ARM    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PASSED  = 3'd1,
    ST_BADREV  = 3'd2,
    ST_FULL    = 3'd3,
    ST_PENDING = 3'd4
  } status_t;

  // One queue entry as stored in memory
  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  tag;
  } entry_t;

  // Request payload as seen by the sequencer
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  request_id;
    logic [63:0] delay;
    logic [63:0] deadline;
    logic [7:0]  revision;
  } req_t;

  // Result fields other than the counter
  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [7:0]  id;
    logic        last;
  } res_t;

  // Result offered by the sequencer to the output register
  typedef struct packed {
    logic        vld;
    res_t        res;
    logic [63:0] counter;
  } emit_t;

endpackage

// File: sv/dtq_req_if.sv
// Request channel interface of the deadline timer queue.
interface dtq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  request_id;
  logic [63:0] delay;
  logic [63:0] deadline;
  logic [7:0]  revision;

  modport source (
    output valid, req_type, request_id, delay, deadline, revision,
    input  ready
  );
  modport sink (
    input  valid, req_type, request_id, delay, deadline, revision,
    output ready
  );
endinterface

// File: sv/dtq_res_if.sv
// Result channel interface of the deadline timer queue.
interface dtq_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [7:0]  result_id;
  logic [63:0] counter_value;
  logic        last;

  modport source (
    output valid, kind, status, result_id, counter_value, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, result_id, counter_value, last,
    output ready
  );
endinterface

// File: sv/dtq_store.sv
// Entry memory of the deadline timer queue: one write port, one registered read port.
module dtq_store import dtq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: the entry appears in the cycle after its address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/dtq_ctrl.sv
// Sequencer of the deadline timer queue: counter, fill count and memory sweeps.
`include "deadline_timer_queue_macros.svh"

module dtq_ctrl import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_req,
  output emit_t         emit,
  input  logic          res_free,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [IW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int MW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_RD,
    S_T_EV,
    S_SC_RD,
    S_SC_EV,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_EMIT
  } state_t;

  state_t        state;
  logic [63:0]   counter;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [MW-1:0] emitted;
  logic          has_pend;
  logic          is_arm;
  logic [63:0]   new_dl;
  logic [7:0]    new_tag;
  logic [CW-1:0] scan_l;
  logic          found;
  logic [CW-1:0] found_l;
  logic [CW-1:0] pos;
  logic [CW-1:0] sh_l;
  res_t          res;

  logic [63:0]   dl_calc;
  logic          rev_bad;
  logic          due;
  logic          last_now;
  logic [IW-1:0] head_inc;

  // Map a queue position to a memory address, starting at head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] l);
    logic [PW-1:0] s;
    s = PW'(hd) + PW'(l);
    if (s >= PW'(QUEUE_DEPTH)) begin
      s = s - PW'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic res_t reply(input status_t st, input logic [7:0] id);
    res_t r;
    r.kind   = KIND_REPLY;
    r.status = st;
    r.id     = id;
    r.last   = 1'b1;
    return r;
  endfunction

  // Resolve the deadline of an arm transaction
  assign dl_calc  = (in_req.delay != 64'd0) ? counter + in_req.delay : in_req.deadline;
  assign rev_bad  = in_req.revision > REV_MAX;
  assign due      = mem_rdata.deadline <= counter;
  assign last_now = (count == CW'(1)) || (emitted == MW'(MAX_RESULTS - 1));
  assign head_inc = (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + IW'(1);

  assign in_ready     = state == S_IDLE;
  assign emit.vld     = state == S_EMIT;
  assign emit.res     = res;
  assign emit.counter = counter;

  // Select memory addresses; reads and writes alternate, so a read never meets a write
  always_comb begin
    unique case (state)
      S_SC_RD: mem_raddr = phys(head, scan_l);
      S_SH_RD: mem_raddr = phys(head, is_arm ? sh_l - CW'(1) : sh_l);
      default: mem_raddr = head;
    endcase
    if (state == S_INS) begin
      mem_waddr = phys(head, pos);
    end else begin
      mem_waddr = phys(head, is_arm ? sh_l : sh_l - CW'(1));
    end
    mem_we = (state == S_SH_WR) || (state == S_INS);
    if (state == S_INS) begin
      mem_wdata.deadline = new_dl;
      mem_wdata.tag      = new_tag;
    end else begin
      mem_wdata = mem_rdata;
    end
  end

  // Sequence each transaction through the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      counter  <= '0;
      head     <= '0;
      count    <= '0;
      emitted  <= '0;
      has_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            new_tag <= in_req.request_id;
            new_dl  <= dl_calc;
            scan_l  <= '0;
            found   <= 1'b0;
            pos     <= '0;
            unique case (req_type_t'(in_req.req_type))
              REQ_TICK: begin
                counter  <= counter + 64'd1;
                emitted  <= '0;
                has_pend <= 1'b0;
                state    <= (count != '0) ? S_T_RD : S_IDLE;
              end
              REQ_ARM: begin
                is_arm <= 1'b1;
                if (rev_bad) begin
                  res   <= reply(ST_BADREV, in_req.request_id);
                  state <= S_EMIT;
                end else if (dl_calc <= counter) begin
                  res   <= reply(ST_PASSED, in_req.request_id);
                  state <= S_EMIT;
                end else begin
                  state <= S_SC_RD;
                end
              end
              REQ_CANCEL: begin
                is_arm <= 1'b0;
                state  <= S_SC_RD;
              end
              REQ_READ: begin
                res   <= reply(rev_bad ? ST_BADREV : ST_OK, in_req.request_id);
                state <= S_EMIT;
              end
            endcase
          end
        end

        // Scan the queue for the tag and the insert position
        S_SC_RD: begin
          if (found || scan_l == count) begin
            if (is_arm) begin
              if (found) begin
                res   <= reply(ST_PENDING, new_tag);
                state <= S_EMIT;
              end else if (count == CW'(QUEUE_DEPTH)) begin
                res   <= reply(ST_FULL, new_tag);
                state <= S_EMIT;
              end else begin
                sh_l  <= count;
                state <= S_SH_RD;
              end
            end else begin
              if (found) begin
                sh_l  <= found_l + CW'(1);
                state <= S_SH_RD;
              end else begin
                res   <= reply(ST_PASSED, new_tag);
                state <= S_EMIT;
              end
            end
          end else begin
            state <= S_SC_EV;
          end
        end
        S_SC_EV: begin
          if (mem_rdata.tag == new_tag) begin
            found   <= 1'b1;
            found_l <= scan_l;
          end
          if (mem_rdata.deadline <= new_dl) begin
            pos <= pos + CW'(1);
          end
          scan_l <= scan_l + CW'(1);
          state  <= S_SC_RD;
        end

        // Shift entries up to open a slot, or down to close one
        S_SH_RD: begin
          if (is_arm) begin
            state <= (sh_l == pos) ? S_INS : S_SH_WR;
          end else if (sh_l == count) begin
            count <= count - CW'(1);
            res   <= reply(ST_OK, new_tag);
            state <= S_EMIT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          sh_l  <= is_arm ? sh_l - CW'(1) : sh_l + CW'(1);
          state <= S_SH_RD;
        end
        S_INS: begin
          count <= count + CW'(1);
          res   <= reply(ST_OK, new_tag);
          state <= S_EMIT;
        end

        // Pop due entries from the head, holding one notice back to learn its last flag
        S_T_RD: begin
          state <= S_T_EV;
        end
        S_T_EV: begin
          if (has_pend) begin
            res.last <= !due;
            has_pend <= 1'b0;
            state    <= S_EMIT;
          end else if (due) begin
            res.kind   <= KIND_EXPIRY;
            res.status <= ST_OK;
            res.id     <= mem_rdata.tag;
            res.last   <= last_now;
            head       <= head_inc;
            count      <= count - CW'(1);
            emitted    <= emitted + MW'(1);
            if (last_now) begin
              state <= S_EMIT;
            end else begin
              has_pend <= 1'b1;
              state    <= S_T_RD;
            end
          end else begin
            state <= S_IDLE;
          end
        end

        // Hand the result to the output register
        S_EMIT: begin
          if (res_free) begin
            state <= res.last ? S_IDLE : S_T_EV;
          end
        end
      endcase
    end
  end

  `DTQ_CHECK(a_count_bound, count <= CW'(QUEUE_DEPTH), "fill count above queue depth")
  `DTQ_CHECK(a_head_bound, PW'(head) < PW'(QUEUE_DEPTH), "head pointer out of range")
  `DTQ_NOW(a_ins_room, state == S_INS, count < CW'(QUEUE_DEPTH), "insert into full queue")
  `DTQ_NEXT(a_emit_hold, emit.vld && !res_free, emit.vld && $stable(emit.res), "result lost")
  `DTQ_CHECK(a_burst_bound, emitted <= MW'(MAX_RESULTS), "too many notices for one tick")

endmodule

// File: sv/deadline_timer_queue.sv
// Deadline timer queue: a 64-bit tick counter and up to QUEUE_DEPTH pending timers kept
// in deadline order in a memory with one write port and one registered read port, used as
// a ring with a fill count (no clearing pass after reset). A tick emits one expiry notice
// per due entry, with at most 16 notices per tick; arm and cancel scan the queue one entry
// at a time and then shift the entries behind the affected slot, alternating a read and a
// write of each entry. Results leave through an output register, so a new transaction is
// taken while the last one waits.
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  dtq_req_if.sink   req,
  dtq_res_if.source res
);

  localparam int IW = $clog2(QUEUE_DEPTH);

  req_t          in_req;
  logic          in_ready;
  emit_t         emit;
  logic          res_free;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          out_valid;
  res_t          out_res;
  logic [63:0]   out_counter;

  assign in_req.req_type   = req.req_type;
  assign in_req.request_id = req.request_id;
  assign in_req.delay      = req.delay;
  assign in_req.deadline   = req.deadline;
  assign in_req.revision   = req.revision;
  assign req.ready         = in_ready;

  dtq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .emit      (emit),
    .res_free  (res_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dtq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Output register takes a new result when empty or being drained
  assign res_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.vld && res_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload of the waiting transaction
  always_ff @(posedge clk) begin
    if (emit.vld && res_free) begin
      out_res     <= emit.res;
      out_counter <= emit.counter;
    end
  end

  assign res.valid         = out_valid;
  assign res.kind          = out_res.kind;
  assign res.status        = out_res.status;
  assign res.result_id     = out_res.id;
  assign res.counter_value = out_counter;
  assign res.last          = out_res.last;

endmodule
